@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
// Depends on nothing; each user includes it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ASSERT_RST(label, clk_sig, rst_n_sig, prop) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error("%m: assertion failed");

// Same, on the usual clk / arst_n pair.
`define ASSERT_CLK(label, prop) \
	`ASSERT_RST(label, clk, arst_n, prop)

`endif

@@ rtl/jrkc_pkg.sv @@
// Package for the required-key checker: transaction types, key table, cell control.
// Used by jrkc_cell, json_required_key_checker_unit and jrkc_checker.
`default_nettype none

package jrkc_pkg;

	localparam int unsigned KEY_COUNT        = 8;
	localparam int unsigned KEY_MAX          = 16;
	localparam int unsigned WINDOW_BYTES_DEF = 16;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// Quoted key names, right-justified: last character in the low byte.
	// 8'h5F is the underscore inside the compound names.
	localparam logic [KEY_MAX*8-1:0] KEY_TEXT [KEY_COUNT] = '{
		"\"nome\"",
		"\"cognome\"",
		{24'h0, "\"nome", 8'h5F, "utente\""},
		{16'h0, "\"data", 8'h5F, "nascita\""},
		{"\"codice", 8'h5F, "fiscale\""},
		"\"email\"",
		"\"password\"",
		{24'h0, "\"tipo", 8'h5F, "utente\""}
	};

	localparam logic [4:0] KEY_LEN [KEY_COUNT] = '{
		5'd6, 5'd9, 5'd13, 5'd14, 5'd16, 5'd7, 5'd10, 5'd13
	};

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_string;
	} in_t;

	typedef struct packed {
		logic       valid_res;
		logic [7:0] keys_found;
	} out_t;

	// Control broadcast to every window cell
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ rtl/jrkc_cell.sv @@
// One window cell: holds one byte, passes it on, and compares the byte it loads
// against every key's character at this cell's distance from the newest byte.
// Depends on jrkc_pkg.
`default_nettype none

module jrkc_cell #(
	parameter int unsigned POS = 0
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire jrkc_pkg::cell_ctl_t            ctl,
	input  wire logic [7:0]                     din,
	output logic      [7:0]                     dout,
	output logic      [jrkc_pkg::KEY_COUNT-1:0] hit
);

	logic [7:0] byte_q;

	// Byte storage; cleared at end of string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctl.clear) begin
			byte_q <= '0;
		end else if (ctl.shift) begin
			byte_q <= din;
		end
	end

	assign dout = byte_q;

	// Per-key compare; positions past a key's length always agree
	for (genvar k = 0; k < jrkc_pkg::KEY_COUNT; k++) begin : g_key
		if (POS < int'(jrkc_pkg::KEY_LEN[k])) begin : g_cmp
			assign hit[k] = (din == jrkc_pkg::KEY_TEXT[k][POS*8 +: 8]);
		end else begin : g_any
			assign hit[k] = 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ rtl/json_required_key_checker_unit.sv @@
// Required-key checker: one byte per cycle, one result per terminator.
// Latency: the result is shown the cycle after the terminator transaction.
// Throughput: one byte every cycle; req_stall rises only while a result waits
// in the output register and rsp_stall holds it.
// Reset: arst_n clears the window cells, key mask, parities and output valid.
// Depends on jrkc_pkg and jrkc_cell.
`default_nettype none

module json_required_key_checker_unit #(
	parameter int unsigned WINDOW_BYTES = jrkc_pkg::WINDOW_BYTES_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire jrkc_pkg::in_t  req_data,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output jrkc_pkg::out_t      rsp_data
);

	localparam int unsigned KC = jrkc_pkg::KEY_COUNT;

	logic                req_take;
	logic                term;
	jrkc_pkg::cell_ctl_t ctl;
	logic [7:0]          chain   [WINDOW_BYTES+1];
	logic [KC-1:0]       cell_hit [WINDOW_BYTES];
	logic [KC-1:0]       key_hit;
	logic [KC-1:0]       found_q;
	logic                brace_q;
	logic                quote_q;
	logic                seen_q;
	logic                out_valid_q;
	jrkc_pkg::out_t      out_q;

	// Handshake and terminator decode
	assign req_stall = out_valid_q && rsp_stall;
	assign req_take  = req_valid && !req_stall;
	assign term      = req_data.end_of_string || (req_data.char_byte == jrkc_pkg::CH_NUL);

	assign ctl.shift = req_take && !term;
	assign ctl.clear = req_take && term;

	// Window: row of cells, newest byte enters cell 0
	assign chain[0] = req_data.char_byte;
	for (genvar j = 0; j < WINDOW_BYTES; j++) begin : g_cell
		jrkc_cell #(
			.POS (j)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.din    (chain[j]),
			.dout   (chain[j+1]),
			.hit    (cell_hit[j])
		);
	end

	// A key matches when every cell agrees
	always_comb begin
		key_hit = '1;
		for (int j = 0; j < WINDOW_BYTES; j++) begin
			key_hit = key_hit & cell_hit[j];
		end
	end

	// String state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= '0;
			brace_q <= 1'b0;
			quote_q <= 1'b0;
			seen_q  <= 1'b0;
		end else if (ctl.clear) begin
			found_q <= '0;
			brace_q <= 1'b0;
			quote_q <= 1'b0;
			seen_q  <= 1'b0;
		end else if (ctl.shift) begin
			found_q <= found_q | key_hit;
			seen_q  <= 1'b1;
			if ((req_data.char_byte == jrkc_pkg::CH_LBRACE) ||
			    (req_data.char_byte == jrkc_pkg::CH_RBRACE)) begin
				brace_q <= !brace_q;
			end
			if (req_data.char_byte == jrkc_pkg::CH_QUOTE) begin
				quote_q <= !quote_q;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.clear) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			out_q.valid_res  <= seen_q && (&found_q) && !brace_q && !quote_q;
			out_q.keys_found <= found_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

endmodule

`default_nettype wire

@@ rtl/jrkc_checker.sv @@
// Port-level checker for json_required_key_checker_unit, attached by bind.
// Depends on jrkc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module jrkc_checker (
	input wire logic           clk,
	input wire logic           arst_n,
	input wire logic           req_valid,
	input wire logic           req_stall,
	input wire jrkc_pkg::in_t  req_data,
	input wire logic           rsp_valid,
	input wire logic           rsp_stall,
	input wire jrkc_pkg::out_t rsp_data
);

	logic term_take;

	assign term_take = req_valid && !req_stall &&
		(req_data.end_of_string || (req_data.char_byte == jrkc_pkg::CH_NUL));

	// Held result stays put
	`ASSERT_CLK(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))

	// A fresh result follows a terminator transaction
	`ASSERT_CLK(a_rsp_cause, $rose(rsp_valid) |-> $past(term_take))

	// Input backs up only behind a held result
	`ASSERT_CLK(a_stall_cause, req_stall |-> rsp_valid && rsp_stall)

	// A passing string has every key
	`ASSERT_CLK(a_pass_keys, rsp_valid && rsp_data.valid_res |-> rsp_data.keys_found == 8'hFF)

	// A taken terminator produces a result next cycle
	`ASSERT_CLK(a_term_rsp, term_take |=> rsp_valid)

endmodule

bind json_required_key_checker_unit jrkc_checker u_jrkc_checker (.*);

`default_nettype wire
